### rtl/core/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants and types for the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int NPOS        = PATTERN_MAX + 1;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int ADDR_W      = $clog2(PATTERN_MAX);

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_NAME   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] symbol;
      logic       last;
   } item_type;

   typedef struct packed {
      logic pattern_too_long;
      logic matched;
   } result_type;

endpackage

### rtl/core/glob_wildcard_matcher_unit.sv
// Path: request beats are registered in the input stage, responses in the result register.
// Throughput: one request beat per cycle while the response side keeps up;
// the input stage stalls only while a held response waits on rsp_tready.
// The core step is one 64-position compare plus a 65-bit add for star runs.
// Reset: synchronous, active high; empties the pattern, drops any name in progress.
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Glob pattern matcher: load a pattern, then stream names and get match results.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] opcode
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);

   item_type   req_item;
   item_type   core_item;
   logic       core_valid;
   logic       core_fire;
   logic       res_valid;
   result_type res;
   logic       out_busy;

   assign req_item.opcode = req_tuser;
   assign req_item.symbol = req_tdata;
   assign req_item.last   = req_tlast;

   // Advance the core only when the result register can take a beat.
   assign core_fire = core_valid && !out_busy;

   gwm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .item_i     (req_item),
      .take_i     (core_fire),
      .valid_o    (core_valid),
      .item_o     (core_item)
   );

   gwm_nfa u_nfa (
      .clock       (clock),
      .reset       (reset),
      .fire_i      (core_fire),
      .item_i      (core_item),
      .res_valid_o (res_valid),
      .res_o       (res)
   );

   gwm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_i     (res_valid),
      .res_i      (res),
      .busy_o     (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/gwm_in_stage.sv
// ----------------------------------------------------------------------------
// gwm_in_stage
// Input register: captures one request beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module gwm_in_stage
   import gwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  item_type item_i,
   input  logic     take_i,
   output logic     valid_o,
   output item_type item_o
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take_i;
   assign valid_in   = req_tvalid || (valid_ff && !take_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_i;
      end
   end

   assign valid_o = valid_ff;
   assign item_o  = item_ff;

endmodule

### rtl/core/gwm_nfa.sv
// ----------------------------------------------------------------------------
// gwm_nfa
// Pattern store and active-position vector; one step per item.
// ----------------------------------------------------------------------------
module gwm_nfa
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire_i,
   input  item_type   item_i,
   output logic       res_valid_o,
   output result_type res_o
);

   logic [7:0]       pat_mem_ff [PATTERN_MAX];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             complete_ff, complete_in;
   logic             ovf_ff, ovf_in;
   logic [NPOS-1:0]  act_ff, act_in;
   logic             in_name_ff, in_name_in;
   logic [NPOS-1:0]  start_ff, start_in;
   logic             pre_star_ff, pre_star_in;

   logic [LEN_W-1:0] base_len;
   logic [LEN_W-1:0] next_len;
   logic [NPOS-1:0]  base_start;
   logic             base_pre;
   logic             wr_en;

   logic [PATTERN_MAX-1:0] live, star, hold, move;
   logic [NPOS-1:0]  cur, adv, star_mask, gen, sum, closed, probe;
   logic             hit;

   assign base_len   = complete_ff ? '0 : len_ff;
   assign next_len   = base_len + LEN_W'(1);
   assign base_start = complete_ff ? NPOS'(1) : start_ff;
   assign base_pre   = complete_ff ? 1'b1 : pre_star_ff;
   assign wr_en      = fire_i && (item_i.opcode == OP_APPEND)
                       && (base_len < LEN_W'(PATTERN_MAX));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem_ff[base_len[ADDR_W-1:0]] <= item_i.symbol;
      end
   end

   // Per-position decode of the stored pattern against the current name byte.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         live[i] = (LEN_W'(i) < len_ff);
         star[i] = (pat_mem_ff[i] == CHAR_STAR) && live[i];
         hold[i] = cur[i] && star[i];
         move[i] = cur[i] && live[i] && !star[i]
                   && ((pat_mem_ff[i] == CHAR_QMARK) || (pat_mem_ff[i] == item_i.symbol));
      end
   end

   assign cur = in_name_ff ? act_ff : start_ff;
   assign adv = {1'b0, hold} | {move, 1'b0};

   // Empty moves through runs of stars ride the carry chain of one add.
   assign star_mask = {1'b0, star};
   assign gen       = adv & star_mask;
   assign sum       = star_mask + gen;
   assign closed    = adv | (sum ^ star_mask ^ gen);

   assign probe = (item_i.opcode == OP_NAME) ? closed : start_ff;
   assign hit   = !ovf_ff && (len_ff != '0) && probe[len_ff];

   always_comb begin
      len_in      = len_ff;
      complete_in = complete_ff;
      ovf_in      = ovf_ff;
      act_in      = act_ff;
      in_name_in  = in_name_ff;
      start_in    = start_ff;
      pre_star_in = pre_star_ff;
      res_valid_o = 1'b0;
      res_o.matched          = hit;
      res_o.pattern_too_long = ovf_ff;
      if (fire_i) begin
         unique case (item_i.opcode)
            OP_APPEND: begin
               in_name_in  = 1'b0;
               complete_in = item_i.last;
               len_in      = base_len;
               ovf_in      = complete_ff ? 1'b0 : ovf_ff;
               start_in    = base_start;
               pre_star_in = base_pre;
               if (base_len < LEN_W'(PATTERN_MAX)) begin
                  len_in = next_len;
                  if (base_pre && (item_i.symbol == CHAR_STAR)) begin
                     start_in[next_len] = 1'b1;
                  end else begin
                     pre_star_in = 1'b0;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            OP_NAME: begin
               act_in      = closed;
               in_name_in  = !item_i.last;
               res_valid_o = item_i.last;
            end
            OP_CLEAR: begin
               len_in      = '0;
               ovf_in      = 1'b0;
               complete_in = 1'b1;
               in_name_in  = 1'b0;
               start_in    = NPOS'(1);
               pre_star_in = 1'b1;
            end
            OP_QUERY: begin
               in_name_in  = 1'b0;
               res_valid_o = 1'b1;
            end
            default: begin
               in_name_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         complete_ff <= 1'b1;
         ovf_ff      <= 1'b0;
         act_ff      <= '0;
         in_name_ff  <= 1'b0;
         start_ff    <= NPOS'(1);
         pre_star_ff <= 1'b1;
      end else begin
         len_ff      <= len_in;
         complete_ff <= complete_in;
         ovf_ff      <= ovf_in;
         act_ff      <= act_in;
         in_name_ff  <= in_name_in;
         start_ff    <= start_in;
         pre_star_ff <= pre_star_in;
      end
   end

endmodule

### rtl/core/gwm_out_stage.sv
// ----------------------------------------------------------------------------
// gwm_out_stage
// Result register: holds one response beat until the sink takes it.
// ----------------------------------------------------------------------------
module gwm_out_stage
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_i,
   input  result_type res_i,
   output logic       busy_o,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign valid_in = load_i || (valid_ff && !rsp_tready);
   assign busy_o   = valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         res_ff <= res_i;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, res_ff.pattern_too_long, res_ff.matched};

endmodule

### rtl/core/gwm_checker.sv
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks for the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
module gwm_checker
   import gwm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Hold a stalled response beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_too_long_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("match reported on an oversized pattern");

   // A fresh response follows an accepted request through the input and result registers.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a matching request");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response pending right after reset");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/gwm_match_checker.sv
// ----------------------------------------------------------------------------
// gwm_match_checker
// Watches both streams of the glob matcher, keeps its own pattern store and
// position vector, and checks every response beat against the oldest
// predicted match result.
// ----------------------------------------------------------------------------
module gwm_match_checker
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] opcode
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [0] matched, [1] pattern_too_long, [7:2] zero
   output int         fail_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [NPOS-1:0] START_POS = NPOS'(1);

   logic [7:0]    pat_mem [PATTERN_MAX];
   int            pat_len;
   bit            pat_closed;
   bit            pat_overflow;
   bit            name_open;
   bit [NPOS-1:0] live_pos;
   result_type    match_q [$];
   result_type    want;

   // Let every active '*' position also enable the one after it, lowest first.
   function automatic bit [NPOS-1:0] follow_stars(bit [NPOS-1:0] v);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < pat_len && v[i] && pat_mem[i] == CHAR_STAR) v[i+1] = 1'b1;
      end
      return v;
   endfunction

   function automatic bit [NPOS-1:0] step_positions(bit [NPOS-1:0] v, logic [7:0] c);
      bit [NPOS-1:0] nxt;
      nxt = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < pat_len && v[i]) begin
            if (pat_mem[i] == CHAR_STAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == CHAR_QMARK || pat_mem[i] == c) nxt[i+1] = 1'b1;
         end
      end
      return follow_stars(nxt);
   endfunction

   function automatic result_type match_result();
      result_type r;
      r.matched          = !pat_overflow && pat_len > 0 && live_pos[pat_len];
      r.pattern_too_long = pat_overflow;
      return r;
   endfunction

   task automatic absorb_beat(logic [1:0] op, logic [7:0] sym, logic fin);
      case (op)
         OP_APPEND: begin
            name_open = 1'b0;
            // A finished pattern is replaced, not extended.
            if (pat_closed) begin
               pat_len      = 0;
               pat_overflow = 1'b0;
               pat_closed   = 1'b0;
            end
            if (pat_len < PATTERN_MAX) begin
               pat_mem[pat_len] = sym;
               pat_len++;
            end else begin
               pat_overflow = 1'b1;
            end
            if (fin) pat_closed = 1'b1;
         end
         OP_NAME: begin
            if (!name_open) begin
               live_pos  = follow_stars(START_POS);
               name_open = 1'b1;
            end
            live_pos = step_positions(live_pos, sym);
            if (fin) begin
               name_open = 1'b0;
               match_q.insert(match_q.size(), match_result());
            end
         end
         OP_CLEAR: begin
            pat_len      = 0;
            pat_overflow = 1'b0;
            pat_closed   = 1'b1;
            name_open    = 1'b0;
         end
         default: begin
            name_open = 1'b0;
            live_pos  = follow_stars(START_POS);
            match_q.insert(match_q.size(), match_result());
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_len      = 0;
         pat_closed   = 1'b1;
         pat_overflow = 1'b0;
         name_open    = 1'b0;
         live_pos     = '0;
         fail_count   = 0;
         match_q.delete();
      end else begin
         if (req_tvalid && req_tready) absorb_beat(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (match_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response beat: expected none, got %h",
                        $realtime, rsp_tdata);
            end else begin
               want = match_q.pop_front();
               if (rsp_tdata[0] !== want.matched) begin
                  fail_count++;
                  $display("%0t: matched: expected %0b, got %b",
                           $realtime, want.matched, rsp_tdata[0]);
               end
               if (rsp_tdata[1] !== want.pattern_too_long) begin
                  fail_count++;
                  $display("%0t: pattern_too_long: expected %0b, got %b",
                           $realtime, want.pattern_too_long, rsp_tdata[1]);
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  fail_count++;
                  $display("%0t: padding bits: expected 00, got %h",
                           $realtime, rsp_tdata[7:2]);
               end
            end
         end
      end
      outstanding = match_q.size();
   end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the glob wildcard matcher: a directed run over empty, star,
// question-mark and incomplete patterns and abandoned names, then random
// pattern loads and names (mostly ones built to match), with random gaps and
// response stalls. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top
   import gwm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BEAT_TARGET = 1250;
   localparam int CALM_FROM   = 1120;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] symbol
   logic [1:0] req_tuser;   // [1:0] opcode
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;   // [0] matched, [1] pattern_too_long, [7:2] zero

   int         fail_count;
   int         outstanding;
   int         beats_sent = 0;
   int         loads_done = 0;
   int         stall_left = 0;
   bit         calm       = 1'b0;
   bit         send_gaps  = 1'b0;
   bit         rsp_stalls = 1'b0;
   bit         pat_open   = 1'b0;
   logic [7:0] cur_pat  [$];
   logic [7:0] name_buf [$];

   always #6 clock = ~clock;

   glob_wildcard_matcher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gwm_match_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Response side: random stall bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls && !calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] pick_pat_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h61;
         3:       return 8'h62;
         4, 5:    return CHAR_STAR;
         6:       return CHAR_QMARK;
         7, 8:    return 8'h63;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_name_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'h61;
         4, 5:       return 8'h62;
         6:          return 8'h63;
         7:          return CHAR_STAR;
         8:          return CHAR_QMARK;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic drive_beat(input logic [1:0] op, input logic [7:0] sym, input logic fin);
      if (send_gaps && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= sym;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      calm = (beats_sent >= CALM_FROM);
   endtask

   // Mirror the pattern in cur_pat so that matching names can be built.
   task automatic put_pattern_byte(input logic [7:0] sym, input logic fin);
      if (!pat_open) cur_pat.delete();
      if (cur_pat.size() < PATTERN_MAX) cur_pat.insert(cur_pat.size(), sym);
      pat_open = !fin;
      drive_beat(OP_APPEND, sym, fin);
   endtask

   task automatic do_clear(input logic [7:0] sym, input logic fin);
      cur_pat.delete();
      pat_open = 1'b0;
      drive_beat(OP_CLEAR, sym, fin);
   endtask

   task automatic load_pattern(input int len);
      for (int i = 0; i < len; i++) put_pattern_byte(pick_pat_byte(), i == len - 1);
   endtask

   task automatic build_name();
      int idx;
      name_buf.delete();
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(0, 10)) name_buf.insert(name_buf.size(), pick_name_byte());
      end else begin
         foreach (cur_pat[i]) begin
            if (cur_pat[i] == CHAR_STAR)
               repeat ($urandom_range(0, 3))
                  name_buf.insert(name_buf.size(), pick_name_byte());
            else if (cur_pat[i] == CHAR_QMARK)
               name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
            else
               name_buf.insert(name_buf.size(), cur_pat[i]);
         end
         if (name_buf.size() > 0 && $urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, name_buf.size() - 1);
            name_buf[idx] = pick_name_byte();
         end
      end
   endtask

   task automatic send_name();
      int cut;
      if (name_buf.size() == 0) begin
         drive_beat(OP_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         return;
      end
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, name_buf.size()) : 0;
      if (cut != 0) begin
         // Abandon the name part way through.
         for (int i = 0; i < cut; i++) drive_beat(OP_NAME, name_buf[i], 1'b0);
         case ($urandom_range(0, 2))
            0:       do_clear(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            1:       drive_beat(OP_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            default: put_pattern_byte(pick_pat_byte(), 1'($urandom_range(0, 1)));
         endcase
      end else begin
         foreach (name_buf[i]) drive_beat(OP_NAME, name_buf[i], i == name_buf.size() - 1);
      end
   endtask

   initial begin
      int pick;
      int len;
      req_tvalid = 1'b0;
      req_tuser  = OP_CLEAR;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      drive_beat(OP_QUERY, 8'hA5, 1'b1);      // empty pattern after reset
      drive_beat(OP_NAME, 8'h78, 1'b1);       // empty pattern never matches
      put_pattern_byte(CHAR_STAR, 1'b1);
      drive_beat(OP_QUERY, 8'h00, 1'b0);      // star against empty name
      drive_beat(OP_NAME, CHAR_STAR, 1'b1);   // star against literal star
      put_pattern_byte(8'h00, 1'b0);
      put_pattern_byte(CHAR_QMARK, 1'b0);
      put_pattern_byte(8'hFF, 1'b1);
      drive_beat(OP_NAME, 8'h00, 1'b0);
      drive_beat(OP_NAME, 8'h41, 1'b0);
      drive_beat(OP_NAME, 8'hFF, 1'b1);
      drive_beat(OP_NAME, 8'h00, 1'b0);
      drive_beat(OP_NAME, 8'hFF, 1'b1);
      drive_beat(OP_NAME, 8'h00, 1'b0);       // dropped by the clear
      do_clear(8'hFF, 1'b1);
      drive_beat(OP_QUERY, 8'h5A, 1'b1);
      put_pattern_byte(8'h61, 1'b0);          // pattern still open
      drive_beat(OP_NAME, 8'h61, 1'b1);
      put_pattern_byte(8'h62, 1'b1);
      drive_beat(OP_NAME, 8'h61, 1'b0);
      drive_beat(OP_QUERY, 8'hC3, 1'b0);      // query drops the partial name
      drive_beat(OP_NAME, 8'h61, 1'b0);
      put_pattern_byte(CHAR_STAR, 1'b1);      // new pattern drops the name
      drive_beat(OP_NAME, 8'h7A, 1'b1);

      // Random part.
      while (beats_sent < BEAT_TARGET) begin
         send_gaps  = !calm && $urandom_range(0, 3) != 0;
         rsp_stalls = !calm && $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            do_clear(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 10) begin
            drive_beat(OP_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 45) begin
            case ($urandom_range(0, 39))
               0:          len = PATTERN_MAX;
               1:          len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
               2, 3, 4, 5: len = $urandom_range(9, 20);
               default:    len = $urandom_range(1, 8);
            endcase
            if (loads_done == 0) len = PATTERN_MAX;
            if (loads_done == 1) len = PATTERN_MAX + 2;
            loads_done++;
            if ($urandom_range(0, 14) == 0) begin
               // Leave the pattern open and match against what is stored.
               for (int i = 0; i < len; i++) put_pattern_byte(pick_pat_byte(), 1'b0);
            end else begin
               load_pattern(len);
            end
            repeat ($urandom_range(1, 4)) begin
               build_name();
               send_name();
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               build_name();
               send_name();
            end
         end
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[glob_wildcard_matcher_unit] OK");
      else
         $display("[glob_wildcard_matcher_unit] ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("[glob_wildcard_matcher_unit] ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/gwm_pkg.sv
rtl/core/gwm_in_stage.sv
rtl/core/gwm_nfa.sv
rtl/core/gwm_out_stage.sv
rtl/core/glob_wildcard_matcher_unit.sv
rtl/core/gwm_checker.sv
verif/gwm_match_checker.sv
verif/tb_top.sv
